@@ src/mtp_pkg.sv @@
// Shared types and constants for the melody text parser.
// Used by mtp_front, mtp_fifo, mtp_back and melody_text_parser; no dependencies.
package mtp_pkg;

   localparam int MAX_NOTES_DEFAULT = 32;
   localparam int MAX_CHARS_DEFAULT = 127;
   localparam logic [15:0] MAX_DURATION_RESET = 16'd10000;

   localparam int FIFO_DEPTH = 4;

   localparam logic KIND_NOTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic        note_valid;
      logic        status_valid;
      logic        success;
      logic [12:0] frequency;
      logic [15:0] duration;
      logic [4:0]  note_seq;
   } event_type;

endpackage

@@ src/mtp_front.sv @@
// Front end: accepts characters, runs the token parser and builds at most one event per beat.
// Depends on mtp_pkg (event_type, reset constants).
module mtp_front #(
   parameter int MAX_NOTES = mtp_pkg::MAX_NOTES_DEFAULT,
   parameter int MAX_CHARS = mtp_pkg::MAX_CHARS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               fifo_full,
   output logic               ev_push,
   output mtp_pkg::event_type ev
);

   localparam int NCW = $clog2(MAX_NOTES + 1);
   localparam int CCW = $clog2(MAX_CHARS + 1);

   localparam logic [3:0] PH_TOKEN  = 4'd0;
   localparam logic [3:0] PH_OCTAVE = 4'd1;
   localparam logic [3:0] PH_COLON  = 4'd2;
   localparam logic [3:0] PH_SPACE  = 4'd3;
   localparam logic [3:0] PH_SIGNED = 4'd4;
   localparam logic [3:0] PH_DIGITS = 4'd5;
   localparam logic [3:0] PH_TAIL   = 4'd6;
   localparam logic [3:0] PH_DONE   = 4'd7;
   localparam logic [3:0] PH_FAILED = 4'd8;

   localparam logic [1:0] ET_NONE = 2'd0;
   localparam logic [1:0] ET_EMIT = 2'd1;
   localparam logic [1:0] ET_FAIL = 2'd2;

   localparam logic [16:0] ACC_CAP = 17'h1FFFF;

   logic [3:0]     phase_ff, phase_in;
   logic [12:0]    freq_ff, freq_in;
   logic [16:0]    acc_ff, acc_in;
   logic [7:0]     letter_ff, letter_in;
   logic [NCW-1:0] nc_ff, nc_in;
   logic [CCW-1:0] cc_ff, cc_in;
   logic           err_ff, err_in;
   logic [15:0]    max_dur_ff;

   logic           fire;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [12:0] freq_of(input logic [7:0] letter, input logic [3:0] oct);
      logic [12:0] b;
      b = '0;
      unique case (upcase(letter))
         8'h43:   b = 13'd262;
         8'h44:   b = 13'd294;
         8'h45:   b = 13'd330;
         8'h46:   b = 13'd349;
         8'h47:   b = 13'd392;
         8'h41:   b = 13'd440;
         8'h42:   b = 13'd494;
         default: b = '0;
      endcase
      if (oct >= 4'd4) begin
         return b << (oct - 4'd4);
      end
      return b >> (4'd4 - oct);
   endfunction

   function automatic logic [1:0] tok_end(input logic [3:0] ph, input logic [16:0] acc,
                                          input logic [15:0] maxd);
      logic [1:0] r;
      r = ET_NONE;
      unique case (ph) inside
         PH_TOKEN, PH_DONE, PH_FAILED: r = ET_NONE;
         PH_DIGITS, PH_TAIL: begin
            r = (acc == '0 || acc > {1'b0, maxd}) ? ET_FAIL : ET_EMIT;
         end
         default: r = ET_FAIL;
      endcase
      return r;
   endfunction

   assign req_tready = !fifo_full;
   assign fire       = req_tvalid && req_tready;

   always_comb begin
      logic [1:0]  code;
      logic [20:0] v;
      logic        active;
      phase_in  = phase_ff;
      freq_in   = freq_ff;
      acc_in    = acc_ff;
      letter_in = letter_ff;
      nc_in     = nc_ff;
      cc_in     = cc_ff;
      err_in    = err_ff;
      ev        = '0;
      code      = ET_NONE;
      v         = '0;
      active    = (cc_ff < CCW'(MAX_CHARS)) && phase_ff != PH_DONE && phase_ff != PH_FAILED;
      if (fire) begin
         if (active) begin
            cc_in = cc_ff + CCW'(1);
            if (req_tdata == 8'h00 || req_tdata == 8'h3B) begin
               code = tok_end(phase_in, acc_in, max_dur_ff);
               if (code == ET_EMIT) begin
                  ev.note_valid = 1'b1;
                  ev.frequency  = freq_in;
                  ev.duration   = acc_in[15:0];
                  ev.note_seq   = 5'(nc_in);
                  nc_in         = nc_in + NCW'(1);
                  phase_in      = (nc_in >= NCW'(MAX_NOTES)) ? PH_DONE : PH_TOKEN;
               end else if (code == ET_FAIL) begin
                  err_in   = 1'b1;
                  phase_in = PH_FAILED;
               end
               if (req_tdata == 8'h00 && phase_in != PH_FAILED) begin
                  phase_in = PH_DONE;
               end
            end else begin
               unique case (phase_ff) inside
                  PH_TOKEN: begin
                     if (upcase(req_tdata) == 8'h4E) begin
                        freq_in  = '0;
                        phase_in = PH_COLON;
                     end else begin
                        letter_in = req_tdata;
                        phase_in  = PH_OCTAVE;
                     end
                  end
                  PH_OCTAVE: begin
                     if (req_tdata >= 8'h30 && req_tdata <= 8'h38) begin
                        freq_in  = freq_of(letter_ff, 4'(req_tdata - 8'h30));
                        phase_in = PH_COLON;
                     end else begin
                        err_in   = 1'b1;
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_COLON: begin
                     if (req_tdata == 8'h3A) begin
                        acc_in   = '0;
                        phase_in = PH_SPACE;
                     end else begin
                        err_in   = 1'b1;
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_SPACE, PH_SIGNED, PH_DIGITS: begin
                     if (req_tdata >= 8'h30 && req_tdata <= 8'h39) begin
                        v = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                            + 21'(req_tdata - 8'h30);
                        acc_in   = (v > 21'(ACC_CAP)) ? ACC_CAP : v[16:0];
                        phase_in = PH_DIGITS;
                     end else if (phase_ff == PH_DIGITS) begin
                        phase_in = PH_TAIL;
                     end else if (phase_ff == PH_SPACE && is_space(req_tdata)) begin
                        phase_in = PH_SPACE;
                     end else if (phase_ff == PH_SPACE && req_tdata == 8'h2B) begin
                        phase_in = PH_SIGNED;
                     end else begin
                        err_in   = 1'b1;
                        phase_in = PH_FAILED;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         if (req_tlast) begin
            code = tok_end(phase_in, acc_in, max_dur_ff);
            if (code == ET_EMIT) begin
               ev.note_valid = 1'b1;
               ev.frequency  = freq_in;
               ev.duration   = acc_in[15:0];
               ev.note_seq   = 5'(nc_in);
               nc_in         = nc_in + NCW'(1);
            end else if (code == ET_FAIL) begin
               err_in = 1'b1;
            end
            ev.status_valid = 1'b1;
            ev.success      = !err_in && (nc_in != '0);
            phase_in  = PH_TOKEN;
            freq_in   = '0;
            acc_in    = '0;
            letter_in = '0;
            nc_in     = '0;
            cc_in     = '0;
            err_in    = 1'b0;
         end
      end
   end

   assign ev_push = fire && (ev.note_valid || ev.status_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TOKEN;
         freq_ff    <= '0;
         acc_ff     <= '0;
         letter_ff  <= '0;
         nc_ff      <= '0;
         cc_ff      <= '0;
         err_ff     <= 1'b0;
         max_dur_ff <= mtp_pkg::MAX_DURATION_RESET;
      end else begin
         phase_ff  <= phase_in;
         freq_ff   <= freq_in;
         acc_ff    <= acc_in;
         letter_ff <= letter_in;
         nc_ff     <= nc_in;
         cc_ff     <= cc_in;
         err_ff    <= err_in;
         if (csr_wr_en) begin
            max_dur_ff <= csr_wr_data;
         end
      end
   end

endmodule

@@ src/mtp_fifo.sv @@
// Event queue between parser front end and result back end.
// Depends on mtp_pkg (event_type, FIFO_DEPTH).
module mtp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mtp_pkg::event_type push_data,
   input  logic               pop,
   output mtp_pkg::event_type head,
   output logic               empty,
   output logic               full
);

   localparam int DEPTH = mtp_pkg::FIFO_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   mtp_pkg::event_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("event queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full event queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty event queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("event queue count did not advance on push");
`endif

endmodule

@@ src/mtp_back.sv @@
// Back end: drains queued events into result beats, note before status.
// Depends on mtp_pkg (event_type, result kind codes).
module mtp_back (
   input  logic               clock,
   input  logic               reset,
   input  mtp_pkg::event_type head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,
   output logic               rsp_tlast,
   output logic [0:0]         rsp_tuser
);

   logic        valid_ff, valid_in;
   logic        sent_ff, sent_in;
   logic        kind_ff, kind_in;
   logic [12:0] freq_ff, freq_in;
   logic [15:0] dur_ff, dur_in;
   logic [4:0]  idx_ff, idx_in;
   logic        ok_ff, ok_in;
   logic        last_ff, last_in;
   logic        load_ok;

   assign load_ok = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      sent_in  = sent_ff;
      kind_in  = kind_ff;
      freq_in  = freq_ff;
      dur_in   = dur_ff;
      idx_in   = idx_ff;
      ok_in    = ok_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load_ok) begin
         valid_in = !empty;
         if (!empty) begin
            if (head.note_valid && !sent_ff) begin
               kind_in = mtp_pkg::KIND_NOTE;
               freq_in = head.frequency;
               dur_in  = head.duration;
               idx_in  = head.note_seq;
               ok_in   = 1'b0;
               last_in = 1'b0;
               if (head.status_valid) begin
                  sent_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               kind_in = mtp_pkg::KIND_STATUS;
               freq_in = '0;
               dur_in  = '0;
               idx_in  = '0;
               ok_in   = head.success;
               last_in = 1'b1;
               sent_in = 1'b0;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_ff  <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      freq_ff <= freq_in;
      dur_ff  <= dur_in;
      idx_ff  <= idx_in;
      ok_ff   <= ok_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, ok_ff, idx_ff, dur_ff, freq_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;

endmodule

@@ src/melody_text_parser.sv @@
// Melody text parser top level: front end, event queue and result back end.
// Depends on mtp_pkg, mtp_front, mtp_fifo and mtp_back.
//
// Takes one melody character per clock on the req_ stream (tlast marks the last
// character of a string) and returns note results and one closing status result
// per string on the rsp_ stream. The front end parses a character in the cycle it
// is accepted, so the block sustains one character per cycle; a string's last
// character that also ends a note gives two results, which the back end issues
// note first, then status, from a four-entry event queue. Input stalls only when
// that queue is full. The user must write the max_duration register through
// csr_wr_en / csr_wr_data only while idle; the block itself does not enforce this.
module melody_text_parser #(
   parameter int MAX_NOTES = mtp_pkg::MAX_NOTES_DEFAULT,
   parameter int MAX_CHARS = mtp_pkg::MAX_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_string
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data, // max_duration
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [12:0] frequency, [28:13] duration,
                                    // [33:29] note position, [34] success, zero fill
   output logic        rsp_tlast,   // last_result
   output logic [0:0]  rsp_tuser    // result_kind
);

   mtp_pkg::event_type ev;
   mtp_pkg::event_type head;
   logic               ev_push;
   logic               pop;
   logic               empty;
   logic               full;

   mtp_front #(
      .MAX_NOTES(MAX_NOTES),
      .MAX_CHARS(MAX_CHARS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fifo_full   (full),
      .ev_push     (ev_push),
      .ev          (ev)
   );

   mtp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   mtp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
